/* rtl/core/vra_pkg.sv */
`default_nettype none
package vra_pkg;

  // Table and address geometry.
  localparam int MAX_RANGES = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_BITS  = 49;

  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int CNT_W = $clog2(MAX_RANGES + 2);
  localparam int ALU_W = ADDR_BITS + 1;

  localparam logic [ADDR_BITS-1:0] ADDR_MASK     = {ADDR_BITS{1'b1}};
  localparam logic [ADDR_BITS-1:0] PAGE_MASK     = ADDR_BITS'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [ADDR_BITS-1:0] DEFAULT_LIMIT = ADDR_BITS'(64'd1 << (ADDR_BITS - 1));
  localparam logic [ADDR_BITS-1:0] MAX_RSIZE_IN  = ADDR_MASK - PAGE_MASK;

  // Command codes.
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_POOL_START = 1'b0;
  localparam logic CFG_POOL_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [ADDR_BITS-1:0] length;
    logic [5:0]           align_shift;
    logic [ADDR_BITS-1:0] addr;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] va;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] len;
  } entry_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             ge;
  } alu_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/vra_alu.sv */
`default_nettype none
module vra_alu (
  input  vra_pkg::alu_req_t req,
  output vra_pkg::alu_rsp_t rsp
);
  import vra_pkg::*;

  logic [ALU_W:0] sum;

  // Add, or subtract through the inverted operand; the carry out of a
  // subtraction says a >= b.
  assign sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{ALU_W{1'b0}}, req.sub};
  assign rsp.res = sum[ALU_W-1:0];
  assign rsp.ge  = sum[ALU_W];

endmodule
`default_nettype wire

/* rtl/core/vra_table.sv */
`default_nettype none
module vra_table (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire  [vra_pkg::IDX_W-1:0]  wr_addr,
  input  vra_pkg::entry_t            wr_data,
  input  wire                        rd_en,
  input  wire  [vra_pkg::IDX_W-1:0]  rd_addr,
  output vra_pkg::entry_t            rd_data
);
  import vra_pkg::*;

  entry_t mem [MAX_RANGES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/va_range_allocator.sv */
`default_nettype none
// First-fit allocator of virtual address space over a sorted, coalesced
// table of free ranges held in a single-port-write, single-port-read memory.
// A command word is taken at a rising edge where start is high and busy is
// low. Command allocate returns the chosen address, free returns the range
// to the table and merges exactly adjacent neighbors, and init loads one
// range from the pool_start and pool_limit registers.
// Each command gives one result word, shown on out_word for exactly one cycle
// with out_valid high; the receiver cannot stall it. Busy stays high from the
// cycle after acceptance until the result is shown, so the next word may be
// started in the result cycle.
// A word rejected on its fields finishes in S_ROUND, init in S_INIT, and
// a free that would pass the top of the address space is rejected in
// S_CHK2. An allocate scans entries up to the fit, then moves entries on a
// split or removal. A free rewrites the table in one pass; with the table
// full a counting pass runs first.
// Configuration words are taken on any cycle (cfg_ready is always high).
// Reset clears the entry count, so the table is empty until init or a free.
module va_range_allocator (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  vra_pkg::in_word_t           in_word,
  output logic                        out_valid,
  output vra_pkg::out_word_t          out_word,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire                         cfg_index,
  input  wire  [vra_pkg::ADDR_BITS-1:0] cfg_data
);
  import vra_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_ROUND = 18'h00002,
    S_INIT  = 18'h00004,
    S_CHK   = 18'h00008,
    S_CHK2  = 18'h00010,
    S_ARD   = 18'h00020,
    S_AAL   = 18'h00040,
    S_ALEAD = 18'h00080,
    S_AREM  = 18'h00100,
    S_ATR   = 18'h00200,
    S_ANB   = 18'h00400,
    S_MRD   = 18'h00800,
    S_MWR   = 18'h01000,
    S_AW1   = 18'h02000,
    S_FRD   = 18'h04000,
    S_FSEL  = 18'h08000,
    S_FSUM  = 18'h10000,
    S_FMRG  = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, m_r, m_nxt;
  logic placed_r, placed_nxt, have_r, have_nxt, dry_r, dry_nxt;
  logic ret_sel_r, ret_sel_nxt, up_r, up_nxt, le_r, le_nxt;
  logic out_valid_r;
  out_word_t out_word_r;
  in_word_t  in_r;
  logic [ADDR_BITS-1:0] pool_start_r, pool_limit_r;
  logic [ADDR_BITS-1:0] rsize_r, rsize_nxt, am_r, am_nxt, b_r, b_nxt;
  logic [ADDR_BITS-1:0] al_r, al_nxt, lead_r, lead_nxt, rem_r, rem_nxt;
  logic [ADDR_BITS-1:0] trail_r, trail_nxt, nb_r, nb_nxt, tmp_r, tmp_nxt;
  logic [ALU_W-1:0]     sum_r, sum_nxt;
  entry_t x_r, x_nxt, acc_r, acc_nxt;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  entry_t   wr_data, rd_data;

  logic fin;
  logic [1:0] fin_st;
  logic [ADDR_BITS-1:0] fin_va;
  logic [5:0] a_eff;
  logic [ADDR_BITS-1:0] bm, orv, limit;

  vra_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  vra_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;

  assign a_eff = (in_r.align_shift < 6'(PAGE_SHIFT)) ? 6'(PAGE_SHIFT) : in_r.align_shift;
  assign bm    = rd_data.base & am_r;
  assign orv   = rd_data.base | am_r;
  assign limit = (pool_limit_r == '0) ? DEFAULT_LIMIT : pool_limit_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    m_nxt       = m_r;
    placed_nxt  = placed_r;
    have_nxt    = have_r;
    dry_nxt     = dry_r;
    ret_sel_nxt = ret_sel_r;
    up_nxt      = up_r;
    le_nxt      = le_r;
    rsize_nxt   = rsize_r;
    am_nxt      = am_r;
    b_nxt       = b_r;
    al_nxt      = al_r;
    lead_nxt    = lead_r;
    rem_nxt     = rem_r;
    trail_nxt   = trail_r;
    nb_nxt      = nb_r;
    tmp_nxt     = tmp_r;
    sum_nxt     = sum_r;
    x_nxt       = x_r;
    acc_nxt     = acc_r;
    alu_req     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    fin         = 1'b0;
    fin_st      = ST_OK;
    fin_va      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_ROUND;
        end
      end

      S_ROUND: begin
        // Round the size up to pages and build the alignment mask.
        alu_req.a = {1'b0, in_r.length};
        alu_req.b = {1'b0, PAGE_MASK};
        rsize_nxt = alu_rsp.res[ADDR_BITS-1:0] & ~PAGE_MASK;
        am_nxt    = (a_eff >= 6'(ADDR_BITS)) ? ADDR_MASK : ~(ADDR_MASK << a_eff);
        priority if (in_r.cmd == CMD_ALLOC) begin
          if (in_r.length == '0) begin
            fin = 1'b1; fin_st = ST_BAD;
          end else if (in_r.length > MAX_RSIZE_IN || count_r == '0) begin
            fin = 1'b1; fin_st = ST_NOFIT;
          end else begin
            i_nxt     = '0;
            state_nxt = S_ARD;
          end
        end else if (in_r.cmd == CMD_FREE) begin
          if (in_r.addr == '0 || in_r.length == '0 || in_r.length > MAX_RSIZE_IN) begin
            fin = 1'b1; fin_st = ST_BAD;
          end else begin
            state_nxt = S_CHK;
          end
        end else if (in_r.cmd == CMD_INIT) begin
          state_nxt = S_INIT;
        end else begin
          fin = 1'b1; fin_st = ST_BAD;
        end
      end

      S_INIT: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, limit};
        alu_req.b   = {1'b0, pool_start_r};
        if (alu_rsp.ge && alu_rsp.res != '0) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = '{base: pool_start_r, len: alu_rsp.res[ADDR_BITS-1:0]};
          count_nxt = CNT_W'(1);
          fin = 1'b1; fin_st = ST_OK;
        end else begin
          fin = 1'b1; fin_st = ST_BAD;
        end
      end

      S_CHK: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, ADDR_MASK};
        alu_req.b   = {1'b0, in_r.addr};
        tmp_nxt     = alu_rsp.res[ADDR_BITS-1:0];
        state_nxt   = S_CHK2;
      end

      S_CHK2: begin
        // The freed range must end at or below the top of the address space.
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, tmp_r};
        alu_req.b   = {1'b0, rsize_r};
        if (!alu_rsp.ge) begin
          fin = 1'b1; fin_st = ST_BAD;
        end else begin
          dry_nxt    = (count_r >= CNT_W'(MAX_RANGES));
          i_nxt      = '0;
          m_nxt      = '0;
          placed_nxt = 1'b0;
          have_nxt   = 1'b0;
          state_nxt  = S_FRD;
        end
      end

      S_ARD: begin
        if (i_r == count_r) begin
          fin = 1'b1; fin_st = ST_NOFIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = i_r[IDX_W-1:0];
          state_nxt = S_AAL;
        end
      end

      S_AAL: begin
        b_nxt       = rd_data.base;
        alu_req.a   = {1'b0, orv};
        alu_req.b   = ALU_W'(1);
        if (bm == '0) begin
          al_nxt    = rd_data.base;
          state_nxt = S_ALEAD;
        end else if (orv == ADDR_MASK) begin
          // The aligned start would pass the top of the address space.
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_ARD;
        end else begin
          al_nxt    = alu_rsp.res[ADDR_BITS-1:0];
          state_nxt = S_ALEAD;
        end
      end

      S_ALEAD: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, al_r};
        alu_req.b   = {1'b0, b_r};
        lead_nxt    = alu_rsp.res[ADDR_BITS-1:0];
        state_nxt   = S_AREM;
      end

      S_AREM: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, rd_data.len};
        alu_req.b   = {1'b0, lead_r};
        rem_nxt     = alu_rsp.res[ADDR_BITS-1:0];
        le_nxt      = alu_rsp.ge;
        state_nxt   = S_ATR;
      end

      S_ATR: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, rem_r};
        alu_req.b   = {1'b0, rsize_r};
        trail_nxt   = alu_rsp.res[ADDR_BITS-1:0];
        if (le_r && alu_rsp.ge) begin
          state_nxt = S_ANB;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_ARD;
        end
      end

      S_ANB: begin
        alu_req.a = {1'b0, al_r};
        alu_req.b = {1'b0, rsize_r};
        nb_nxt    = alu_rsp.res[ADDR_BITS-1:0];
        priority if (lead_r != '0 && trail_r != '0) begin
          // A split needs one more entry; shift the tail up first.
          if (count_r >= CNT_W'(MAX_RANGES)) begin
            fin = 1'b1; fin_st = ST_FULL;
          end else begin
            up_nxt    = 1'b1;
            j_nxt     = count_r;
            state_nxt = S_MRD;
          end
        end else if (lead_r != '0) begin
          wr_en   = 1'b1;
          wr_addr = i_r[IDX_W-1:0];
          wr_data = '{base: b_r, len: lead_r};
          fin = 1'b1; fin_st = ST_OK; fin_va = al_r;
        end else if (trail_r != '0) begin
          wr_en   = 1'b1;
          wr_addr = i_r[IDX_W-1:0];
          wr_data = '{base: alu_rsp.res[ADDR_BITS-1:0], len: trail_r};
          fin = 1'b1; fin_st = ST_OK; fin_va = al_r;
        end else begin
          // Exact fit: the entry goes away and the tail shifts down.
          up_nxt    = 1'b0;
          j_nxt     = i_r + CNT_W'(1);
          state_nxt = S_MRD;
        end
      end

      S_MRD: begin
        if (up_r) begin
          if (j_r == i_r + CNT_W'(1)) begin
            state_nxt = S_AW1;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = IDX_W'(j_r - CNT_W'(1));
            state_nxt = S_MWR;
          end
        end else begin
          if (j_r == count_r) begin
            count_nxt = count_r - CNT_W'(1);
            fin = 1'b1; fin_st = ST_OK; fin_va = al_r;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = j_r[IDX_W-1:0];
            state_nxt = S_MWR;
          end
        end
      end

      S_MWR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
        if (up_r) begin
          wr_addr = j_r[IDX_W-1:0];
          j_nxt   = j_r - CNT_W'(1);
        end else begin
          wr_addr = IDX_W'(j_r - CNT_W'(1));
          j_nxt   = j_r + CNT_W'(1);
        end
        state_nxt = S_MRD;
      end

      S_AW1: begin
        // Second half of a split: the lead stays, then the trail goes above.
        wr_en   = 1'b1;
        if (!le_r) begin
          wr_addr   = IDX_W'(i_r + CNT_W'(1));
          wr_data   = '{base: nb_r, len: trail_r};
          count_nxt = count_r + CNT_W'(1);
          fin = 1'b1; fin_st = ST_OK; fin_va = al_r;
        end else begin
          wr_addr = i_r[IDX_W-1:0];
          wr_data = '{base: b_r, len: lead_r};
          le_nxt  = 1'b0;
        end
      end

      S_FRD: begin
        if (i_r == count_r) begin
          if (!placed_r) begin
            x_nxt       = '{base: in_r.addr, len: rsize_r};
            placed_nxt  = 1'b1;
            ret_sel_nxt = 1'b0;
            state_nxt   = S_FSUM;
          end else begin
            // End the pass: flush the last merged range, or check a dry run.
            if (!dry_r) begin
              wr_en     = 1'b1;
              wr_addr   = m_r[IDX_W-1:0];
              wr_data   = acc_r;
              count_nxt = m_r + CNT_W'(1);
              fin = 1'b1; fin_st = ST_OK;
            end else if (m_r + CNT_W'(1) > CNT_W'(MAX_RANGES)) begin
              fin = 1'b1; fin_st = ST_FULL;
            end else begin
              dry_nxt    = 1'b0;
              i_nxt      = '0;
              m_nxt      = '0;
              placed_nxt = 1'b0;
              have_nxt   = 1'b0;
            end
          end
        end else begin
          rd_en     = 1'b1;
          rd_addr   = i_r[IDX_W-1:0];
          state_nxt = S_FSEL;
        end
      end

      S_FSEL: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, rd_data.base};
        alu_req.b   = {1'b0, in_r.addr};
        if (!placed_r && alu_rsp.ge) begin
          x_nxt       = '{base: in_r.addr, len: rsize_r};
          placed_nxt  = 1'b1;
          ret_sel_nxt = 1'b1;
        end else begin
          x_nxt       = rd_data;
          i_nxt       = i_r + CNT_W'(1);
          ret_sel_nxt = 1'b0;
        end
        state_nxt = S_FSUM;
      end

      S_FSUM: begin
        alu_req.a = {1'b0, acc_r.base};
        alu_req.b = {1'b0, acc_r.len};
        sum_nxt   = alu_rsp.res;
        state_nxt = S_FMRG;
      end

      S_FMRG: begin
        alu_req.a = {1'b0, acc_r.len};
        alu_req.b = {1'b0, x_r.len};
        if (have_r && sum_r == {1'b0, x_r.base}) begin
          acc_nxt.len = alu_rsp.res[ADDR_BITS-1:0];
        end else begin
          if (have_r) begin
            wr_en   = !dry_r;
            wr_addr = m_r[IDX_W-1:0];
            wr_data = acc_r;
            m_nxt   = m_r + CNT_W'(1);
          end
          acc_nxt  = x_r;
          have_nxt = 1'b1;
        end
        state_nxt = ret_sel_r ? S_FSEL : S_FRD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      pool_start_r <= '0;
      pool_limit_r <= '0;
      le_r         <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= fin;
      le_r        <= le_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_POOL_START: pool_start_r <= cfg_data;
          CFG_POOL_LIMIT: pool_limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_word;
    end
    if (fin) begin
      out_word_r.status <= fin_st;
      out_word_r.va     <= (fin_st == ST_OK) ? fin_va : '0;
    end
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    m_r       <= m_nxt;
    placed_r  <= placed_nxt;
    have_r    <= have_nxt;
    dry_r     <= dry_nxt;
    ret_sel_r <= ret_sel_nxt;
    up_r      <= up_nxt;
    rsize_r   <= rsize_nxt;
    am_r      <= am_nxt;
    b_r       <= b_nxt;
    al_r      <= al_nxt;
    lead_r    <= lead_nxt;
    rem_r     <= rem_nxt;
    trail_r   <= trail_nxt;
    nb_r      <= nb_nxt;
    tmp_r     <= tmp_nxt;
    sum_r     <= sum_nxt;
    x_r       <= x_nxt;
    acc_r     <= acc_nxt;
  end

  // The result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  // An accepted word always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  // The table never holds more ranges than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RANGES))
    else $error("range count above table depth");

  // A failed request reports address zero.
  a_fail_va: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status != ST_OK) |-> out_word_r.va == '0)
    else $error("nonzero address on failed request");

endmodule
`default_nettype wire

/* tb/va_range_allocator_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module va_range_allocator_tb;
  import vra_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;

  // The allocator is shaped as a single-slot command engine: one word in,
  // one result word out, nothing overlapping except the result cycle.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_valid;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [ADDR_BITS-1:0] cfg_data = '0;

  va_range_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the free-range table, its count and the pool registers.
  logic [ADDR_BITS-1:0] free_base [MAX_RANGES];
  logic [ADDR_BITS-1:0] free_len [MAX_RANGES];
  int unsigned free_count = 0;
  logic [ADDR_BITS-1:0] pool_start_reg = '0;
  logic [ADDR_BITS-1:0] pool_limit_reg = '0;

  in_word_t pending_words[$];
  out_word_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit idle_enable = 1'b1;
  int unsigned send_gap = 0;

  // Pages are rounded in 64-bit arithmetic so that carries out of the
  // address width are seen rather than lost.
  function automatic bit page_round(input logic [63:0] length, output logic [63:0] rsize);
    rsize = 0;
    if (length > 64'(ADDR_MASK) - 64'(PAGE_MASK)) return 1'b0;
    rsize = (length + 64'(PAGE_MASK)) & ~64'(PAGE_MASK);
    return 1'b1;
  endfunction

  function automatic out_word_t predict_command(input in_word_t w);
    out_word_t r;
    logic [63:0] rsize, am, b, l, al, lead, trail, addr, lim;
    logic [63:0] wb [MAX_RANGES+1];
    logic [63:0] wl [MAX_RANGES+1];
    int unsigned a, k, m;
    bit placed, found;
    r = '0;
    r.status = ST_BAD;
    addr = 64'(w.addr);
    case (w.cmd)
      CMD_INIT: begin
        lim = (pool_limit_reg == 0) ? 64'(DEFAULT_LIMIT) : 64'(pool_limit_reg);
        if (64'(pool_start_reg) < lim) begin
          free_base[0] = pool_start_reg;
          free_len[0] = ADDR_BITS'(lim - 64'(pool_start_reg));
          free_count = 1;
          r.status = ST_OK;
        end
      end
      CMD_ALLOC: begin
        if (w.length == 0) r.status = ST_BAD;
        else if (!page_round(64'(w.length), rsize)) r.status = ST_NOFIT;
        else begin
          a = (w.align_shift < PAGE_SHIFT) ? PAGE_SHIFT : w.align_shift;
          am = (64'd1 << a) - 1;
          r.status = ST_NOFIT;
          found = 1'b0;
          for (int i = 0; i < free_count && !found; i++) begin
            b = 64'(free_base[i]);
            l = 64'(free_len[i]);
            if ((b & am) == 0) al = b;
            else if ((b | am) >= 64'(ADDR_MASK)) continue;
            else al = (b | am) + 1;
            lead = al - b;
            if (lead > l || l - lead < rsize) continue;
            trail = l - lead - rsize;
            found = 1'b1;
            if (lead > 0 && trail > 0) begin
              if (free_count >= MAX_RANGES) begin
                r.status = ST_FULL;
              end else begin
                for (int j = free_count; j > i + 1; j--) begin
                  free_base[j] = free_base[j-1];
                  free_len[j] = free_len[j-1];
                end
                free_len[i] = ADDR_BITS'(lead);
                free_base[i+1] = ADDR_BITS'(al + rsize);
                free_len[i+1] = ADDR_BITS'(trail);
                free_count++;
                r.status = ST_OK;
              end
            end else if (lead > 0) begin
              free_len[i] = ADDR_BITS'(lead);
              r.status = ST_OK;
            end else if (trail > 0) begin
              free_base[i] = ADDR_BITS'(al + rsize);
              free_len[i] = ADDR_BITS'(trail);
              r.status = ST_OK;
            end else begin
              for (int j = i; j + 1 < free_count; j++) begin
                free_base[j] = free_base[j+1];
                free_len[j] = free_len[j+1];
              end
              free_count--;
              r.status = ST_OK;
            end
            if (r.status == ST_OK) r.va = ADDR_BITS'(al);
          end
        end
      end
      CMD_FREE: begin
        if (addr == 0 || w.length == 0) r.status = ST_BAD;
        else if (!page_round(64'(w.length), rsize) || rsize > 64'(ADDR_MASK) - addr)
          r.status = ST_BAD;
        else begin
          // Insert in address order, then merge exactly adjacent ranges.
          k = 0;
          placed = 1'b0;
          for (int i = 0; i < free_count; i++) begin
            if (!placed && 64'(free_base[i]) >= addr) begin
              wb[k] = addr; wl[k] = rsize; k++; placed = 1'b1;
            end
            wb[k] = 64'(free_base[i]); wl[k] = 64'(free_len[i]); k++;
          end
          if (!placed) begin
            wb[k] = addr; wl[k] = rsize; k++;
          end
          m = 0;
          for (int i = 0; i < k; i++) begin
            if (m > 0 && wb[m-1] + wl[m-1] == wb[i]) wl[m-1] += wl[i];
            else begin
              wb[m] = wb[i]; wl[m] = wl[i]; m++;
            end
          end
          if (m > MAX_RANGES) r.status = ST_FULL;
          else begin
            for (int i = 0; i < m; i++) begin
              free_base[i] = ADDR_BITS'(wb[i]);
              free_len[i] = ADDR_BITS'(wl[i]);
            end
            free_count = m;
            r.status = ST_OK;
          end
        end
      end
      default: r.status = ST_BAD;
    endcase
    if (r.status != ST_OK) r.va = '0;
    return r;
  endfunction

  // Driver: presents the next pending word and holds it until accepted.
  // The expectation is computed at the accepting edge, in command order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(predict_command(in_word));
        void'(pending_words.pop_front());
      end
      if (start && busy) begin
        // Hold the word until the allocator takes it.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        start <= 1'b0;
      end else if (pending_words.size() > 0
                   && !(idle_enable && $urandom_range(0, 15) == 0)) begin
        start <= 1'b1;
        in_word <= pending_words[0];
      end else begin
        start <= 1'b0;
        if (idle_enable && pending_words.size() > 0) send_gap <= $urandom_range(0, 18);
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %p", out_word);
      end else begin
        if (out_word.status !== expected_results[0].status ||
            out_word.va !== expected_results[0].va) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d va %h, got status %0d va %h",
                     expected_results[0].status, expected_results[0].va,
                     out_word.status, out_word.va);
        end
        void'(expected_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_word_t make_word(input logic [1:0] cmd, input logic [63:0] length,
                                         input int unsigned shift, input logic [63:0] addr);
    in_word_t w;
    w.cmd = cmd;
    w.length = ADDR_BITS'(length);
    w.align_shift = 6'(shift);
    w.addr = ADDR_BITS'(addr);
    return w;
  endfunction

  function automatic logic [63:0] rand_wide();
    return {$urandom(), $urandom()} & 64'(ADDR_MASK);
  endfunction

  // Waits until the queue and the allocator drain, then lets any
  // in-flight work settle before a register is touched.
  task automatic drain();
    while (pending_words.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= ADDR_BITS'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_POOL_START) pool_start_reg = ADDR_BITS'(value);
    else pool_limit_reg = ADDR_BITS'(value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // A random word with a bias toward small page counts, so the table fills
  // with many ranges and splits, merges and full-table cases get exercised.
  function automatic in_word_t random_word(input logic [63:0] lo, input logic [63:0] hi);
    logic [63:0] length, addr;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    length = ($urandom_range(0, 9) == 0) ? rand_wide()
           : 64'($urandom_range(1, 24)) * 4096 - $urandom_range(0, 4095);
    addr = ($urandom_range(0, 19) == 0) ? rand_wide()
         : lo + ((64'($urandom()) << 12) % (hi - lo + 1) & ~64'hfff);
    if (sel < 55)
      return make_word(CMD_ALLOC, length,
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 16), 0);
    if (sel < 95) return make_word(CMD_FREE, length, $urandom_range(0, 63), addr);
    if (sel < 97) return make_word(CMD_INIT, rand_wide(), $urandom_range(0, 63), rand_wide());
    return make_word(2'd3, rand_wide(), $urandom_range(0, 63), rand_wide());
  endfunction

  initial begin
    logic [63:0] starts [4];
    logic [63:0] limits [4];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, bad and unknown commands, extremes of fields.
    pending_words.push_back(make_word(CMD_ALLOC, 4096, 0, 0));
    pending_words.push_back(make_word(CMD_FREE, 8192, 0, 64'h10000));
    pending_words.push_back(make_word(CMD_FREE, 4096, 0, 64'h12000));
    pending_words.push_back(make_word(CMD_ALLOC, 1, 12, 0));
    pending_words.push_back(make_word(CMD_FREE, 0, 0, 64'h5000));
    pending_words.push_back(make_word(CMD_FREE, 4096, 0, 0));
    pending_words.push_back(make_word(CMD_FREE, 64'(ADDR_MASK), 63, 64'(ADDR_MASK)));
    pending_words.push_back(make_word(CMD_FREE, 4096, 0, 64'(ADDR_MASK) - 4096));
    pending_words.push_back(make_word(2'd3, 64'(ADDR_MASK), 63, 64'(ADDR_MASK)));
    pending_words.push_back(make_word(CMD_INIT, 0, 0, 0));
    pending_words.push_back(make_word(CMD_ALLOC, 0, 0, 0));
    pending_words.push_back(make_word(CMD_ALLOC, 64'(ADDR_MASK), 0, 0));
    pending_words.push_back(make_word(CMD_ALLOC, 4097, 48, 0));
    pending_words.push_back(make_word(CMD_ALLOC, 4096, 63, 0));
    pending_words.push_back(make_word(CMD_ALLOC, 12288, 20, 0));
    pending_words.push_back(make_word(CMD_ALLOC, 64'h7ff_ffff_f000, 0, 0));
    pending_words.push_back(make_word(CMD_FREE, 12288, 0, 64'h100000));
    pending_words.push_back(make_word(CMD_ALLOC, 4096, 0, 0));
    drain();

    // Configuration sweep: bad init, tiny pool, full pool, default limit.
    starts = '{64'(ADDR_MASK), 64'h1000, 64'h1000, 64'h4000_0000};
    limits = '{64'h1000, 64'h41000, 64'(ADDR_MASK), 0};
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_POOL_START, starts[p]);
      write_reg(CFG_POOL_LIMIT, limits[p]);
      pending_words.push_back(make_word(CMD_INIT, 0, 0, 0));
      if (p == 3) idle_enable = 1'b0;
      for (int n = 0; n < 410; n++)
        pending_words.push_back(random_word(starts[p] & 64'h1_ffff_ffff_ffff,
                                            (p == 1) ? 64'h41000 : starts[p] + 64'h400000));
      drain();
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
